[src/mi3_pkg.sv]
`default_nettype none

package mi3_pkg;

    localparam int NEL   = 9;
    localparam int DW    = 32;
    localparam int ADJW  = 64;
    localparam int DETW  = 98;
    localparam int MAGW  = DETW - 1;
    localparam int QBITS = DW + 1;

    localparam int PA [NEL] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int PB [NEL] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int NA [NEL] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int NB [NEL] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef logic [NEL-1:0][DW-1:0]   mat_t;
    typedef logic [2:0][DW-1:0]       row_t;
    typedef logic [NEL-1:0][ADJW-1:0] adj_vec_t;

    typedef struct packed {
        logic valid;
        logic singular;
    } pipe_ctl_t;

    typedef struct packed {
        logic [MAGW-1:0]  rem;
        logic [QBITS-1:0] low;
        logic [QBITS-1:0] quo;
        logic             neg;
        logic             ovf;
    } div_lane_t;

    typedef div_lane_t [NEL-1:0] lane_vec_t;

endpackage

`default_nettype wire

[src/mi3_cofactor.sv]
`default_nettype none

module mi3_cofactor
    import mi3_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire mat_t     m,
    output logic          out_valid,
    output adj_vec_t      adj,
    output row_t          row0
);

    logic [NEL-1:0][ADJW-1:0] pp_reg, pn_reg, pp_next, pn_next;
    adj_vec_t                 adj_reg, adj_next;
    row_t                     r1_reg, r2_reg;
    logic                     v1_reg, v2_reg;

    always_comb
    begin
        for (int i = 0; i < NEL; i++)
        begin
            pp_next[i] = $signed(m[PA[i]]) * $signed(m[PB[i]]);
            pn_next[i] = $signed(m[NA[i]]) * $signed(m[NB[i]]);
            adj_next[i] = pp_reg[i] - pn_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg  <= pp_next;
            pn_reg  <= pn_next;
            r1_reg  <= row_t'({m[2], m[1], m[0]});
            adj_reg <= adj_next;
            r2_reg  <= r1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign adj       = adj_reg;
    assign row0      = r2_reg;

endmodule

`default_nettype wire

[src/mi3_det.sv]
`default_nettype none

module mi3_det
    import mi3_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire adj_vec_t      adj_in,
    input  wire row_t          row0,
    output logic               out_valid,
    output adj_vec_t           adj,
    output logic [DETW-1:0]    det
);

    logic signed [2:0][DW+ADJW/2+1:0] plo_reg, plo_next;
    logic signed [2:0][ADJW-1:0]      phi_reg, phi_next;
    logic [2:0][DETW-1:0]             term_reg, term_next;
    logic [DETW-1:0]                  det_reg, det_next;
    adj_vec_t                         a3_reg, a4_reg, a5_reg;
    logic                             v3_reg, v4_reg, v5_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            plo_next[k] = $signed(row0[k]) * $signed({1'b0, adj_in[3*k][ADJW/2-1:0]});
            phi_next[k] = $signed(row0[k]) * $signed(adj_in[3*k][ADJW-1:ADJW/2]);
            term_next[k] = (DETW'($signed(phi_reg[k])) <<< (ADJW/2))
                         + DETW'($signed(plo_reg[k]));
        end
        det_next = term_reg[0] + term_reg[1] + term_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            a3_reg   <= adj_in;
            term_reg <= term_next;
            a4_reg   <= a3_reg;
            det_reg  <= det_next;
            a5_reg   <= a4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign adj       = a5_reg;
    assign det       = det_reg;

endmodule

`default_nettype wire

[src/mi3_div_step.sv]
`default_nettype none

module mi3_div_step
    import mi3_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire pipe_ctl_t       ctl_in,
    input  wire logic [MAGW-1:0] dmag_in,
    input  wire lane_vec_t       lanes_in,
    output pipe_ctl_t            ctl_out,
    output logic [MAGW-1:0]      dmag_out,
    output lane_vec_t            lanes_out
);

    pipe_ctl_t       ctl_reg;
    logic [MAGW-1:0] dmag_reg;
    lane_vec_t       lanes_reg, lanes_next;
    logic [MAGW:0]   trial, diff;
    logic            ge;

    always_comb
    begin
        trial = '0;
        diff  = '0;
        ge    = 1'b0;
        for (int i = 0; i < NEL; i++)
        begin
            trial = {lanes_in[i].rem, lanes_in[i].low[QBITS-1]};
            diff  = trial - {1'b0, dmag_in};
            ge    = trial >= {1'b0, dmag_in};
            lanes_next[i].rem = ge ? diff[MAGW-1:0] : trial[MAGW-1:0];
            lanes_next[i].low = {lanes_in[i].low[QBITS-2:0], 1'b0};
            lanes_next[i].quo = {lanes_in[i].quo[QBITS-2:0], ge};
            lanes_next[i].neg = lanes_in[i].neg;
            lanes_next[i].ovf = lanes_in[i].ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg  <= dmag_in;
            lanes_reg <= lanes_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign dmag_out  = dmag_reg;
    assign lanes_out = lanes_reg;

endmodule

`default_nettype wire

[src/matrix3x3_inverse.sv]
// Pipeline stages from request to result: 2 cofactor, 3 determinant,
// 2 setup, 33 divide steps, 1 output stage.
// Throughput: one request per cycle; every stage advances together and a
// stalled result holds the whole pipeline.
// Reset clears all valid bits; data registers are not reset.
`default_nettype none

module matrix3x3_inverse
    import mi3_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        mat_valid,
    output logic             mat_stall,
    input  wire logic [31:0] m00,
    input  wire logic [31:0] m01,
    input  wire logic [31:0] m02,
    input  wire logic [31:0] m10,
    input  wire logic [31:0] m11,
    input  wire logic [31:0] m12,
    input  wire logic [31:0] m20,
    input  wire logic [31:0] m21,
    input  wire logic [31:0] m22,
    output logic             inv_valid,
    input  wire logic        inv_stall,
    output logic [31:0]      inv00,
    output logic [31:0]      inv01,
    output logic [31:0]      inv02,
    output logic [31:0]      inv10,
    output logic [31:0]      inv11,
    output logic [31:0]      inv12,
    output logic [31:0]      inv20,
    output logic [31:0]      inv21,
    output logic [31:0]      inv22,
    output logic             singular,
    output logic             saturated
);

    localparam int NUMW = ADJW + 2 * FRACTION_BITS;
    localparam int CMPW = MAGW + QBITS + 1;
    localparam logic [QBITS-1:0] POS_MAX = QBITS'(32'h7FFF_FFFF);
    localparam logic [QBITS-1:0] NEG_MAX = QBITS'(32'h8000_0000);

    logic            en;
    mat_t            mat;
    logic            cof_valid, det_valid;
    adj_vec_t        cof_adj, det_adj;
    row_t            cof_row0;
    logic [DETW-1:0] det;

    logic [NEL-1:0][NUMW-1:0] num_reg, num_next;
    logic [NEL-1:0]           neg_reg, neg_next;
    logic [MAGW-1:0]          dmag6_reg, dmag6_next;
    pipe_ctl_t                ctl6_reg;
    logic [ADJW-1:0]          amag;

    lane_vec_t                lane7_next;
    pipe_ctl_t                ctl_s  [QBITS+1];
    logic [MAGW-1:0]          dmag_s [QBITS+1];
    lane_vec_t                lane_s [QBITS+1];

    logic [NEL-1:0][DW-1:0]   res_reg, res_next;
    logic                     sing_reg, sat_reg, sat_next;
    logic                     vout_reg;

    assign en        = !(vout_reg && inv_stall);
    assign mat_stall = !en;
    assign mat = {m22, m21, m20, m12, m11, m10, m02, m01, m00};

    mi3_cofactor u_cof (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mat_valid),
        .m         (mat),
        .out_valid (cof_valid),
        .adj       (cof_adj),
        .row0      (cof_row0)
    );

    mi3_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cof_valid),
        .adj_in    (cof_adj),
        .row0      (cof_row0),
        .out_valid (det_valid),
        .adj       (det_adj),
        .det       (det)
    );

    always_comb
    begin
        amag       = '0;
        dmag6_next = det[DETW-1] ? MAGW'(-det) : det[MAGW-1:0];
        for (int i = 0; i < NEL; i++)
        begin
            amag        = det_adj[i][ADJW-1] ? -det_adj[i] : det_adj[i];
            num_next[i] = {amag, {(2 * FRACTION_BITS){1'b0}}};
            neg_next[i] = det_adj[i][ADJW-1] ^ det[DETW-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NEL; i++)
        begin
            lane7_next[i].rem = MAGW'(num_reg[i][NUMW-1:QBITS]);
            lane7_next[i].low = num_reg[i][QBITS-1:0];
            lane7_next[i].quo = '0;
            lane7_next[i].neg = neg_reg[i];
            lane7_next[i].ovf = CMPW'(num_reg[i]) >= {1'b0, dmag6_reg, {QBITS{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl6_reg  <= '0;
            ctl_s[0]  <= '0;
        end
        else if (en)
        begin
            ctl6_reg.valid    <= det_valid;
            ctl6_reg.singular <= (det == '0);
            ctl_s[0]          <= ctl6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg   <= num_next;
            neg_reg   <= neg_next;
            dmag6_reg <= dmag6_next;
            dmag_s[0] <= dmag6_reg;
            lane_s[0] <= lane7_next;
        end
    end

    for (genvar k = 0; k < QBITS; k++)
    begin : g_step
        mi3_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .ctl_in    (ctl_s[k]),
            .dmag_in   (dmag_s[k]),
            .lanes_in  (lane_s[k]),
            .ctl_out   (ctl_s[k+1]),
            .dmag_out  (dmag_s[k+1]),
            .lanes_out (lane_s[k+1])
        );
    end

    always_comb
    begin
        sat_next = 1'b0;
        for (int i = 0; i < NEL; i++)
        begin
            if (ctl_s[QBITS].singular)
            begin
                res_next[i] = '0;
            end
            else if (!lane_s[QBITS][i].neg)
            begin
                if (lane_s[QBITS][i].ovf || lane_s[QBITS][i].quo > POS_MAX)
                begin
                    res_next[i] = POS_MAX[DW-1:0];
                    sat_next    = 1'b1;
                end
                else
                begin
                    res_next[i] = lane_s[QBITS][i].quo[DW-1:0];
                end
            end
            else
            begin
                if (lane_s[QBITS][i].ovf || lane_s[QBITS][i].quo > NEG_MAX)
                begin
                    res_next[i] = NEG_MAX[DW-1:0];
                    sat_next    = 1'b1;
                end
                else
                begin
                    res_next[i] = -lane_s[QBITS][i].quo[DW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            vout_reg <= ctl_s[QBITS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg  <= res_next;
            sing_reg <= ctl_s[QBITS].singular;
            sat_reg  <= sat_next;
        end
    end

    assign inv_valid = vout_reg;
    assign inv00     = res_reg[0];
    assign inv01     = res_reg[1];
    assign inv02     = res_reg[2];
    assign inv10     = res_reg[3];
    assign inv11     = res_reg[4];
    assign inv12     = res_reg[5];
    assign inv20     = res_reg[6];
    assign inv21     = res_reg[7];
    assign inv22     = res_reg[8];
    assign singular  = sing_reg;
    assign saturated = sat_reg;

    a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && singular |-> !saturated)
        else $error("singular result flagged as saturated");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && singular |-> inv00 == '0 && inv11 == '0 && inv22 == '0)
        else $error("singular result with nonzero elements");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        mat_stall |-> inv_valid && inv_stall)
        else $error("input stalled without a stalled result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv_stall |=> inv_valid && $stable(inv00) && $stable(saturated))
        else $error("stalled result changed");

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int FB = 16;
    localparam int N_RAND = 1200;
    localparam int WATCHDOG = 20000;
    localparam int DRAIN = 200;

    typedef struct {
        logic [8:0][31:0] inv;
        logic             sing;
        logic             sat;
    } inverse_t;

    typedef struct {
        logic [8:0][31:0] m;
        logic             known;
        inverse_t         res;
    } row_entry_t;

    logic clk;
    logic rst_n;
    logic mat_valid;
    logic mat_stall;
    logic [8:0][31:0] mat;
    logic inv_valid;
    logic inv_stall;
    logic [8:0][31:0] inv;
    logic singular;
    logic saturated;

    inverse_t   pending_q[$];
    row_entry_t table_rows[$];
    int errors;
    int idle_cycles;
    bit no_idle;
    bit timed_out;
    int hold_rx;

    matrix3x3_inverse #(.FRACTION_BITS(FB)) dut (
        .clk(clk), .rst_n(rst_n),
        .mat_valid(mat_valid), .mat_stall(mat_stall),
        .m00(mat[0]), .m01(mat[1]), .m02(mat[2]),
        .m10(mat[3]), .m11(mat[4]), .m12(mat[5]),
        .m20(mat[6]), .m21(mat[7]), .m22(mat[8]),
        .inv_valid(inv_valid), .inv_stall(inv_stall),
        .inv00(inv[0]), .inv01(inv[1]), .inv02(inv[2]),
        .inv10(inv[3]), .inv11(inv[4]), .inv12(inv[5]),
        .inv20(inv[6]), .inv21(inv[7]), .inv22(inv[8]),
        .singular(singular), .saturated(saturated)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic inverse_t invert_matrix(logic [8:0][31:0] m);
        inverse_t r;
        logic signed [127:0] e [9];
        logic signed [127:0] cof [9];
        logic signed [127:0] det;
        logic [127:0] dmag;
        logic [127:0] amag;
        logic [127:0] q;
        logic neg;
        for (int i = 0; i < 9; i++)
            e[i] = {{96{m[i][31]}}, m[i]};
        cof[0] = e[4] * e[8] - e[5] * e[7];
        cof[1] = e[2] * e[7] - e[1] * e[8];
        cof[2] = e[1] * e[5] - e[2] * e[4];
        cof[3] = e[5] * e[6] - e[3] * e[8];
        cof[4] = e[0] * e[8] - e[2] * e[6];
        cof[5] = e[2] * e[3] - e[0] * e[5];
        cof[6] = e[3] * e[7] - e[4] * e[6];
        cof[7] = e[1] * e[6] - e[0] * e[7];
        cof[8] = e[0] * e[4] - e[1] * e[3];
        det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
        r.sat = 1'b0;
        r.sing = (det == 0);
        r.inv = '0;
        if (r.sing)
            return r;
        dmag = det < 0 ? -det : det;
        for (int i = 0; i < 9; i++)
        begin
            amag = cof[i] < 0 ? -cof[i] : cof[i];
            q = (amag << (2 * FB)) / dmag;
            neg = (cof[i] < 0) != (det < 0);
            if (!neg)
            begin
                if (q > 128'h7FFF_FFFF)
                begin
                    r.inv[i] = 32'h7FFF_FFFF;
                    r.sat = 1'b1;
                end
                else
                    r.inv[i] = q[31:0];
            end
            else if (q > 128'h8000_0000)
            begin
                r.inv[i] = 32'h8000_0000;
                r.sat = 1'b1;
            end
            else
                r.inv[i] = -q[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic logic [8:0][31:0] rand_matrix();
        logic [8:0][31:0] m;
        int r;
        for (int i = 0; i < 9; i++)
            m[i] = rand_elem();
        case ($urandom_range(0, 7))
            0:
            begin
                r = $urandom_range(0, 2);
                for (int c = 0; c < 3; c++)
                    m[((r + 1) % 3) * 3 + c] = m[r * 3 + c];
            end
            1:
            begin
                m = '0;
                m[0] = rand_elem();
                m[4] = rand_elem();
                m[8] = rand_elem();
            end
            default: ;
        endcase
        return m;
    endfunction

    task automatic add_row(logic [8:0][31:0] m, logic known, inverse_t res);
        row_entry_t t;
        t.m = m;
        t.known = known;
        t.res = res;
        table_rows.push_back(t);
    endtask

    task automatic send_matrix(logic [8:0][31:0] m, logic known, inverse_t res);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            mat_valid <= 1'b0;
            mat <= {9{32'($urandom)}};
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        mat_valid <= 1'b1;
        mat <= m;
        pending_q.push_back(known ? res : invert_matrix(m));
        @(posedge clk);
        while (mat_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (no_idle)
            inv_stall <= 1'b0;
        else if (hold_rx != 0)
            hold_rx = hold_rx - 1;
        else if ($urandom_range(0, 9) == 0)
        begin
            hold_rx = $urandom_range(0, 16);
            inv_stall <= 1'b1;
        end
        else
            inv_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && (inv_valid && !inv_stall || mat_valid && !mat_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && inv_valid && !inv_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result", $time);
                errors++;
            end
            else
            begin
                inverse_t x;
                x = pending_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (inv[i] !== x.inv[i])
                    begin
                        $display("%0t: inv%0d%0d expected %h actual %h", $time,
                                 i / 3, i % 3, x.inv[i], inv[i]);
                        errors++;
                    end
                if (singular !== x.sing)
                begin
                    $display("%0t: singular expected %b actual %b", $time, x.sing, singular);
                    errors++;
                end
                if (saturated !== x.sat)
                begin
                    $display("%0t: saturated expected %b actual %b", $time, x.sat, saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG && !timed_out)
        begin
            timed_out = 1'b1;
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [8:0][31:0] m;
        inverse_t r;
        rst_n = 1'b0;
        mat_valid = 1'b0;
        inv_stall = 1'b0;
        mat = '0;
        errors = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        timed_out = 1'b0;
        hold_rx = 0;

        r.inv = '0; r.sing = 1'b1; r.sat = 1'b0;
        add_row('0, 1'b1, r);
        m = '0; m[0] = 32'h0001_0000; m[4] = 32'h0001_0000; m[8] = 32'h0001_0000;
        r.inv = m; r.sing = 1'b0;
        add_row(m, 1'b1, r);
        m = '0; m[0] = 32'h0002_0000; m[4] = 32'hFFFE_0000; m[8] = 32'h0000_8000;
        r.inv = '0; r.inv[0] = 32'h0000_8000; r.inv[4] = 32'hFFFF_8000;
        r.inv[8] = 32'h0002_0000;
        add_row(m, 1'b1, r);
        m = '0; m[0] = 1; m[4] = 1; m[8] = 1;
        r.inv = '0; r.inv[0] = 32'h7FFF_FFFF; r.inv[4] = 32'h7FFF_FFFF;
        r.inv[8] = 32'h7FFF_FFFF; r.sat = 1'b1;
        add_row(m, 1'b1, r);
        m = '0; m[0] = 32'hFFFF_FFFF; m[4] = 1; m[8] = 1;
        r.inv[0] = 32'h8000_0000;
        add_row(m, 1'b1, r);
        r.sat = 1'b0;
        m = {9{32'h7FFF_FFFF}};
        r.inv = '0; r.sing = 1'b1;
        add_row(m, 1'b1, r);
        m = {9{32'h8000_0000}};
        add_row(m, 1'b1, r);
        m = '0; m[0] = 32'h7FFF_FFFF; m[4] = 32'h8000_0000; m[8] = 32'h7FFF_FFFF;
        add_row(m, 1'b0, r);
        m = '0; m[0] = 32'h8000_0000; m[4] = 32'h8000_0000; m[8] = 32'h8000_0000;
        add_row(m, 1'b0, r);
        m = '0; m[2] = 32'h0001_0000; m[4] = 32'h0003_0000; m[6] = 32'hFFFF_0000;
        add_row(m, 1'b0, r);
        m = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h1234_5678, 32'hFFFF_FFFF,
             32'h8000_0001, 32'h0001_0000, 32'h5555_5555, 32'hAAAA_AAAA};
        add_row(m, 1'b0, r);
        m = {32'h0002_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0002_0000,
             32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0002_0000};
        add_row(m, 1'b0, r);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (table_rows[i])
            send_matrix(table_rows[i].m, table_rows[i].known, table_rows[i].res);
        mat_valid <= 1'b0;

        // hold the sender until the pipeline drains
        while (pending_q.size() != 0)
            @(negedge clk);

        for (int i = 0; i < N_RAND; i++)
        begin
            if (i == N_RAND - 150)
                no_idle = 1'b1;
            send_matrix(rand_matrix(), 1'b0, r);
        end
        mat_valid <= 1'b0;

        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
